// ===== design/mbe_pkg.sv =====
package mbe_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS     = 28;
    localparam int ITER_BITS     = 16;
    localparam int ROW_BITS      = 12;
    localparam int COL_BITS      = 12;
    localparam int STEP_BITS     = 31;
    localparam int MAG_BITS      = 36;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int WIDE_BITS     = 2 * COORD_BITS;
    localparam int PROD_BITS     = COL_BITS + STEP_BITS;
    localparam int SUM_BITS      = PROD_BITS + 2;

    localparam logic signed [WIDE_BITS-1:0] COORD_MAX =
        (WIDE_BITS'(64'sd1) <<< (COORD_BITS - 1)) - WIDE_BITS'(64'sd1);
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN = -COORD_MAX - WIDE_BITS'(64'sd1);
    localparam logic [WIDE_BITS-1:0] ESC_LIMIT = WIDE_BITS'(64'd4) << (2 * FRAC_BITS);

    localparam logic signed [COORD_BITS-1:0] X_MIN_RST    = -32'sd536870912;
    localparam logic signed [COORD_BITS-1:0] Y_MAX_RST    = 32'sd402653184;
    localparam logic [STEP_BITS-1:0]         STEP_X_RST   = 31'd1048576;
    localparam logic [STEP_BITS-1:0]         STEP_Y_RST   = 31'd1048576;
    localparam logic [ITER_BITS-1:0]         MAX_ITER_RST = 16'd256;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_MIN    = 3'd0,
        REG_Y_MAX    = 3'd1,
        REG_STEP_X   = 3'd2,
        REG_STEP_Y   = 3'd3,
        REG_MAX_ITER = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_MUL   = 2'd2,
        ST_EVAL  = 2'd3
    } state_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] column;
    } in_item_t;

    typedef struct packed {
        logic [ITER_BITS-1:0] iteration_count;
        logic                 inside_res;
        logic [MAG_BITS-1:0]  final_magnitude_sq;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic step;
        logic capture;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        if (v > COORD_MAX)
        begin
            r = COORD_MAX[COORD_BITS-1:0];
        end
        else if (v < COORD_MIN)
        begin
            r = COORD_MIN[COORD_BITS-1:0];
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/mbe_ctrl.sv =====
module mbe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  mbe_pkg::dp_status_t status,
    output mbe_pkg::dp_cmd_t    cmd
);
    import mbe_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!status.done)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.capture || (out_valid_reg && out_stall);
    end

endmodule

// ===== design/mbe_datapath.sv =====
module mbe_datapath #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mbe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  mbe_pkg::in_item_t                   in_data,
    input  mbe_pkg::dp_cmd_t                    cmd,
    output mbe_pkg::dp_status_t                 status,
    output mbe_pkg::out_item_t                  out_data
);
    import mbe_pkg::*;

    localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(MAX_COLUMNS - 1);

    logic signed [COORD_BITS-1:0] x_min_reg;
    logic signed [COORD_BITS-1:0] y_max_reg;
    logic [STEP_BITS-1:0]         step_x_reg;
    logic [STEP_BITS-1:0]         step_y_reg;
    logic [ITER_BITS-1:0]         max_iter_reg;

    logic [PROD_BITS-1:0]         prod_re_reg;
    logic [PROD_BITS-1:0]         prod_im_reg;
    logic signed [COORD_BITS-1:0] c_re_reg;
    logic signed [COORD_BITS-1:0] c_im_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [WIDE_BITS-1:0]  xx_reg;
    logic signed [WIDE_BITS-1:0]  yy_reg;
    logic signed [WIDE_BITS-1:0]  xy_reg;
    logic [ITER_BITS-1:0]         count_reg;
    out_item_t                    out_reg;

    logic [COL_BITS-1:0]          col_eff;
    logic [PROD_BITS-1:0]         prod_re_next;
    logic [PROD_BITS-1:0]         prod_im_next;
    logic signed [SUM_BITS-1:0]   sum_re;
    logic signed [SUM_BITS-1:0]   sum_im;
    logic signed [COORD_BITS-1:0] c_re_next;
    logic signed [COORD_BITS-1:0] c_im_next;
    logic signed [WIDE_BITS-1:0]  xx_next;
    logic signed [WIDE_BITS-1:0]  yy_next;
    logic signed [WIDE_BITS-1:0]  xy_next;
    logic [WIDE_BITS-1:0]         mag;
    logic signed [WIDE_BITS-1:0]  diff;
    logic signed [WIDE_BITS-1:0]  nx_wide;
    logic signed [WIDE_BITS-1:0]  ny_wide;
    logic                         escaped;
    logic                         at_limit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg    <= X_MIN_RST;
            y_max_reg    <= Y_MAX_RST;
            step_x_reg   <= STEP_X_RST;
            step_y_reg   <= STEP_Y_RST;
            max_iter_reg <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X_MIN:    x_min_reg    <= cfg_data[COORD_BITS-1:0];
                REG_Y_MAX:    y_max_reg    <= cfg_data[COORD_BITS-1:0];
                REG_STEP_X:   step_x_reg   <= cfg_data[STEP_BITS-1:0];
                REG_STEP_Y:   step_y_reg   <= cfg_data[STEP_BITS-1:0];
                REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // start point: c = (x_min + col*step_x, y_max - row*step_y)
    assign col_eff      = (32'(in_data.column) >= 32'(MAX_COLUMNS)) ? COL_LAST
                                                                     : in_data.column;
    assign prod_re_next = PROD_BITS'(col_eff) * PROD_BITS'(step_x_reg);
    assign prod_im_next = PROD_BITS'(in_data.row) * PROD_BITS'(step_y_reg);
    assign sum_re       = SUM_BITS'(x_min_reg) + $signed({2'b00, prod_re_reg});
    assign sum_im       = SUM_BITS'(y_max_reg) - $signed({2'b00, prod_im_reg});
    assign c_re_next    = sat_coord(WIDE_BITS'(sum_re));
    assign c_im_next    = sat_coord(WIDE_BITS'(sum_im));

    // iteration: products first, then escape test and update
    assign xx_next  = WIDE_BITS'(x_reg) * WIDE_BITS'(x_reg);
    assign yy_next  = WIDE_BITS'(y_reg) * WIDE_BITS'(y_reg);
    assign xy_next  = WIDE_BITS'(x_reg) * WIDE_BITS'(y_reg);
    assign mag      = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign escaped  = (mag >= ESC_LIMIT);
    assign at_limit = (count_reg >= max_iter_reg);
    assign diff     = xx_reg - yy_reg;
    assign nx_wide  = (diff >>> FRAC_BITS) + WIDE_BITS'(c_re_reg);
    assign ny_wide  = (xy_reg >>> (FRAC_BITS - 1)) + WIDE_BITS'(c_im_reg);

    assign status.done = escaped || at_limit;
    assign out_data    = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
        if (cmd.setup)
        begin
            c_re_reg  <= c_re_next;
            c_im_reg  <= c_im_next;
            x_reg     <= c_re_next;
            y_reg     <= c_im_next;
            count_reg <= '0;
        end
        if (cmd.mul)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            xy_reg <= xy_next;
        end
        if (cmd.step)
        begin
            x_reg     <= sat_coord(nx_wide);
            y_reg     <= sat_coord(ny_wide);
            count_reg <= count_reg + ITER_BITS'(1);
        end
        if (cmd.capture)
        begin
            out_reg.iteration_count    <= count_reg;
            out_reg.inside_res         <= (count_reg == max_iter_reg);
            out_reg.final_magnitude_sq <= mag[FRAC_BITS +: MAG_BITS];
        end
    end

endmodule

// ===== design/mandelbrot_escape_time.sv =====
// Channel   Direction  Payload                     Handshake
// in        input      in_data  (row, column)      in_valid / in_stall
// out       output     out_data (count, inside,    out_valid / out_stall
//                                |z|^2)
// cfg       input      cfg_index, cfg_data         cfg_we
//
// A pixel is loaded on acceptance, set up, then iterated; its result is
// captured at the end and the next pixel is taken once control is idle. Each
// iteration passes the three 32x32 multipliers, then the escape test and update.
// Reset clears control and loads the default view and limit of 256.
// A waiting result does not block the next pixel, which runs until its
// own result is ready and then waits for the output register to free.
module mandelbrot_escape_time #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  mbe_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output mbe_pkg::out_item_t                out_data
);
    import mbe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mbe_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ===== design/mbe_checker.sv =====
module mbe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input mbe_pkg::out_item_t out_data
);
    import mbe_pkg::*;

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one pixel at a time: busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a pixel is in flight");

    // a new result comes from a busy block that has just gone idle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall && $past(in_stall))
        else $error("result appeared without a pixel in flight");

    // an escaped point has |z|^2 of at least 4
    a_escape_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.inside_res |->
            out_data.final_magnitude_sq[MAG_BITS-1:FRAC_BITS+2] != '0)
        else $error("escaped point below the escape radius");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
